// ===== hw/rtl/rkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkvc_pkg
// Types and constants shared by the rotary knob volume controller.
// ----------------------------------------------------------------------------
package rkvc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W = 16;
	localparam int VOL_W = 7;
	localparam int OFS_W = 8;
	localparam int STEP_W = 4;

	localparam logic [VOL_W-1:0] VOL_CEIL = 7'd100;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	localparam logic [VOL_W-1:0] INIT_VOL_RST = 7'd0;
	localparam logic [CNT_W-1:0] ENC_LOCK_RST = 16'd100;
	localparam logic [CNT_W-1:0] BTN_LOCK_RST = 16'd200;
	localparam logic [CNT_W-1:0] ADJ_TIMEOUT_RST = 16'd3000;
	localparam logic [STEP_W-1:0] VOL_STEP_RST = 4'd2;
	localparam logic [VOL_W-1:0] OFS_LIMIT_RST = 7'd50;
	localparam logic [VOL_W-1:0] MAX_VOL_RST = 7'd100;

	typedef enum logic [1:0] {
		MODE_MAIN = 2'd0,
		MODE_ADJUST = 2'd1,
		MODE_MENU = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_VOLUME = 3'd0,
		CFG_ENCODER_LOCKOUT = 3'd1,
		CFG_BUTTON_LOCKOUT = 3'd2,
		CFG_ADJUST_TIMEOUT = 3'd3,
		CFG_VOLUME_STEP = 3'd4,
		CFG_OFFSET_LIMIT = 3'd5,
		CFG_MAX_VOLUME = 3'd6
	} cfg_idx_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

	function automatic logic [VOL_W-1:0] cap100(input logic [VOL_W-1:0] v);
		cap100 = (v > VOL_CEIL) ? VOL_CEIL : v;
	endfunction

endpackage

// ===== hw/rtl/rotary_knob_volume_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_knob_volume_controller
// Encoder decode, debounced mode switch and volume/offset/menu update.
// ----------------------------------------------------------------------------
// Result: an accepted item's result is registered in the output register.
// Throughput: one item per cycle; the single output register is refilled in
// the cycle it is taken, so input stall only rises while a result is held.
// Reset: asynchronous, active low; settings take their reset values, master
// volume is zero and the mode is main.
module rotary_knob_volume_controller #(
	parameter int MENU_ENTRIES = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  pin_a,
	input  logic                                  pin_b,
	input  logic                                  pin_sw,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [rkvc_pkg::VOL_W-1:0]            first_volume,
	output logic [rkvc_pkg::VOL_W-1:0]            second_volume,
	output logic                                  send_both,
	output logic                                  send_second,
	output logic [1:0]                            ui_mode,
	output logic [1:0]                            menu_index,
	output logic signed [rkvc_pkg::OFS_W-1:0]     offset_value,
	output logic                                  menu_action,
	output logic                                  redraw,
	input  logic                                  cfg_wr_en,
	input  logic [rkvc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rkvc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import rkvc_pkg::*;

	localparam int MENU_W = (MENU_ENTRIES > 1) ? $clog2(MENU_ENTRIES) : 1;
	localparam logic [MENU_W-1:0] MENU_LAST = MENU_W'(MENU_ENTRIES - 1);

	// settings
	logic [CNT_W-1:0]  enc_lock_q, btn_lock_q, adj_timeout_q;
	logic [STEP_W-1:0] vol_step_q;
	logic [VOL_W-1:0]  ofs_limit_q, max_vol_q;

	// tick state
	logic              prev_a_q, b_at_fall_q, prev_sw_q;
	logic [CNT_W-1:0]  enc_wait_q, btn_wait_q, idle_q;
	mode_t             mode_q;
	logic [MENU_W-1:0] menu_pos_q;
	logic [VOL_W-1:0]  master_q;
	logic signed [OFS_W-1:0] offset_q;

	// next state
	logic              b_at_fall_n;
	logic [CNT_W-1:0]  enc_wait_n, btn_wait_n, idle_n;
	mode_t             mode_n;
	logic [MENU_W-1:0] menu_pos_n;
	logic [VOL_W-1:0]  master_n;
	logic signed [OFS_W-1:0] offset_n;
	logic              send_both_n, send_second_n, action_n, redraw_n;
	logic [VOL_W-1:0]  second_n;

	logic [VOL_W-1:0]  maxv, lim;
	logic              edge_ok, step_up, step_dn, press;
	logic [CNT_W-1:0]  ew, bw, it;
	mode_t             mode_t0;
	logic signed [OFS_W+1:0] ofs_sum, lim_s, sec_sum;
	logic signed [VOL_W+1:0] mst_sum, maxv_s;
	logic [MENU_W+1:0] menu_ext;

	// result register
	logic              out_valid_q;
	logic [VOL_W-1:0]  first_vol_q, second_vol_q;
	logic              send_both_q, send_second_q, action_q, redraw_q;
	mode_t             ui_mode_q;
	logic [MENU_W-1:0] menu_idx_q;
	logic signed [OFS_W-1:0] offset_out_q;

	logic in_acc;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign maxv   = cap100(max_vol_q);
	assign lim    = cap100(ofs_limit_q);
	assign maxv_s = $signed({2'b00, maxv});
	assign lim_s  = $signed({3'b000, lim});

	always_comb begin
		ew = sat_inc(enc_wait_q);
		bw = sat_inc(btn_wait_q);
		it = sat_inc(idle_q);

		edge_ok     = (pin_a != prev_a_q) && (ew >= enc_lock_q);
		b_at_fall_n = (edge_ok && !pin_a) ? pin_b : b_at_fall_q;
		step_dn     = edge_ok && pin_a && b_at_fall_q && !pin_b;
		step_up     = edge_ok && pin_a && !b_at_fall_q && pin_b;
		enc_wait_n  = (step_up || step_dn) ? '0 : ew;

		idle_n        = it;
		mode_t0       = mode_q;
		redraw_n      = 1'b0;
		send_both_n   = 1'b0;
		send_second_n = 1'b0;
		action_n      = 1'b0;
		menu_pos_n    = menu_pos_q;
		master_n      = master_q;
		offset_n      = offset_q;

		if (mode_q == MODE_ADJUST && it > adj_timeout_q) begin
			mode_t0  = MODE_MAIN;
			redraw_n = 1'b1;
		end

		ofs_sum = step_up ? $signed({{2{offset_q[OFS_W-1]}}, offset_q})
				+ $signed({6'b0, vol_step_q})
			: $signed({{2{offset_q[OFS_W-1]}}, offset_q}) - $signed({6'b0, vol_step_q});
		mst_sum = step_up ? $signed({2'b00, master_q}) + $signed({5'b0, vol_step_q})
			: $signed({2'b00, master_q}) - $signed({5'b0, vol_step_q});

		if (step_up || step_dn) begin
			redraw_n = 1'b1;
			unique case (mode_t0)
				MODE_MENU: begin
					if (step_up && menu_pos_q != MENU_LAST)
						menu_pos_n = menu_pos_q + 1'b1;
					else if (step_dn && menu_pos_q != '0)
						menu_pos_n = menu_pos_q - 1'b1;
				end
				MODE_ADJUST: begin
					if (ofs_sum < -lim_s)
						offset_n = OFS_W'(-lim_s);
					else if (ofs_sum > lim_s)
						offset_n = OFS_W'(lim_s);
					else
						offset_n = OFS_W'(ofs_sum);
					idle_n        = '0;
					send_second_n = 1'b1;
				end
				default: begin
					if (mst_sum < 0)
						master_n = '0;
					else if (mst_sum > maxv_s)
						master_n = maxv;
					else
						master_n = VOL_W'(mst_sum);
					if (master_n == '0)
						offset_n = '0;
					send_both_n = 1'b1;
				end
			endcase
		end

		press      = !pin_sw && prev_sw_q && (bw > btn_lock_q);
		btn_wait_n = press ? '0 : bw;
		mode_n     = mode_t0;
		if (press) begin
			redraw_n = 1'b1;
			unique case (mode_t0)
				MODE_MENU: begin
					action_n = (menu_pos_n != MENU_LAST);
					mode_n   = MODE_MAIN;
				end
				MODE_ADJUST: begin
					mode_n     = MODE_MENU;
					menu_pos_n = '0;
				end
				default: begin
					mode_n = MODE_ADJUST;
					idle_n = '0;
				end
			endcase
		end
	end

	// second speaker volume from the updated state
	always_comb begin
		sec_sum = $signed({3'b000, master_n}) + $signed({{2{offset_n[OFS_W-1]}}, offset_n});
		if (master_n == '0 && !send_second_n)
			second_n = '0;
		else if (sec_sum < 0)
			second_n = '0;
		else if (sec_sum > $signed({3'b000, maxv}))
			second_n = maxv;
		else
			second_n = VOL_W'(sec_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_lock_q    <= ENC_LOCK_RST;
			btn_lock_q    <= BTN_LOCK_RST;
			adj_timeout_q <= ADJ_TIMEOUT_RST;
			vol_step_q    <= VOL_STEP_RST;
			ofs_limit_q   <= OFS_LIMIT_RST;
			max_vol_q     <= MAX_VOL_RST;
			prev_a_q      <= 1'b1;
			b_at_fall_q   <= 1'b0;
			enc_wait_q    <= ENC_LOCK_RST;
			prev_sw_q     <= 1'b1;
			btn_wait_q    <= BTN_LOCK_RST;
			idle_q        <= '0;
			mode_q        <= MODE_MAIN;
			menu_pos_q    <= '0;
			master_q      <= INIT_VOL_RST;
			offset_q      <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INITIAL_VOLUME: begin
					master_q <= (cfg_data[VOL_W-1:0] > maxv) ? maxv : cfg_data[VOL_W-1:0];
				end
				CFG_ENCODER_LOCKOUT: enc_lock_q <= cfg_data;
				CFG_BUTTON_LOCKOUT:  btn_lock_q <= cfg_data;
				CFG_ADJUST_TIMEOUT:  adj_timeout_q <= cfg_data;
				CFG_VOLUME_STEP:     vol_step_q <= cfg_data[STEP_W-1:0];
				CFG_OFFSET_LIMIT:    ofs_limit_q <= cfg_data[VOL_W-1:0];
				CFG_MAX_VOLUME:      max_vol_q <= cfg_data[VOL_W-1:0];
				default: ;
			endcase
		end else if (in_acc) begin
			prev_a_q    <= pin_a;
			b_at_fall_q <= b_at_fall_n;
			enc_wait_q  <= enc_wait_n;
			prev_sw_q   <= pin_sw;
			btn_wait_q  <= btn_wait_n;
			idle_q      <= idle_n;
			mode_q      <= mode_n;
			menu_pos_q  <= menu_pos_n;
			master_q    <= master_n;
			offset_q    <= offset_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			first_vol_q   <= master_n;
			second_vol_q  <= second_n;
			send_both_q   <= send_both_n;
			send_second_q <= send_second_n;
			ui_mode_q     <= mode_n;
			menu_idx_q    <= menu_pos_n;
			offset_out_q  <= offset_n;
			action_q      <= action_n;
			redraw_q      <= redraw_n;
		end
	end

	assign menu_ext      = {2'b00, menu_idx_q};
	assign out_valid     = out_valid_q;
	assign first_volume  = first_vol_q;
	assign second_volume = second_vol_q;
	assign send_both     = send_both_q;
	assign send_second   = send_second_q;
	assign ui_mode       = ui_mode_q;
	assign menu_index    = menu_ext[1:0];
	assign offset_value  = offset_out_q;
	assign menu_action   = action_q;
	assign redraw        = redraw_q;

	a_strobes_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(send_both && send_second))
		else $error("both send strobes in one item");

	a_first_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_volume <= VOL_CEIL)
		else $error("master volume above ceiling");

	a_action_main: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && menu_action |-> ui_mode == MODE_MAIN)
		else $error("menu action outside return to main");

	a_strobe_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (send_both || send_second || menu_action) |-> redraw)
		else $error("strobe without redraw");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(first_volume)
			&& $stable(offset_value))
		else $error("held result overwritten");

endmodule

// ===== tb/knob_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_check_pkg
// Result tracking for the rotary knob volume controller bench. Works out the
// expected result of every accepted tick from its own copy of the settings
// and control state, and checks results from the block in order.
// ----------------------------------------------------------------------------
package knob_check_pkg;

	import rkvc_pkg::*;

	localparam int MENU_COUNT = 4;

	typedef struct packed {
		logic [VOL_W-1:0] first_volume;
		logic [VOL_W-1:0] second_volume;
		logic             send_both;
		logic             send_second;
		logic [1:0]       ui_mode;
		logic [1:0]       menu_index;
		logic [OFS_W-1:0] offset_value;
		logic             menu_action;
		logic             redraw;
	} knob_result_t;

	class knob_scoreboard;

		logic [VOL_W-1:0]  init_vol, ofs_lim, max_vol;
		logic [CNT_W-1:0]  enc_lock, btn_lock, adj_to;
		logic [STEP_W-1:0] step;

		bit               prev_a, b_latch, prev_sw;
		logic [CNT_W-1:0] enc_wait, btn_wait, idle_cnt;
		mode_t            mode;
		int               menu_pos, master, offset;

		knob_result_t expected_q[$];
		int n_results, n_bad, n_steps, n_presses, n_actions, n_timeouts;

		function new();
			init_vol = INIT_VOL_RST;
			enc_lock = ENC_LOCK_RST;
			btn_lock = BTN_LOCK_RST;
			adj_to = ADJ_TIMEOUT_RST;
			step = VOL_STEP_RST;
			ofs_lim = OFS_LIMIT_RST;
			max_vol = MAX_VOL_RST;
			prev_a = 1'b1;
			b_latch = 1'b0;
			prev_sw = 1'b1;
			enc_wait = enc_lock;
			btn_wait = btn_lock;
			idle_cnt = '0;
			mode = MODE_MAIN;
			menu_pos = 0;
			master = int'(init_vol);
			offset = 0;
			n_results = 0;
			n_bad = 0;
			n_steps = 0;
			n_presses = 0;
			n_actions = 0;
			n_timeouts = 0;
		endfunction

		function int clip(int v, int lo, int hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function logic [CNT_W-1:0] tick_up(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function int vol_ceiling();
			return (max_vol > VOL_CEIL) ? int'(VOL_CEIL) : int'(max_vol);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_setting(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_INITIAL_VOLUME: begin
					init_vol = d[VOL_W-1:0];
					master = clip(int'(init_vol), 0, vol_ceiling());
				end
				CFG_ENCODER_LOCKOUT: enc_lock = d;
				CFG_BUTTON_LOCKOUT: btn_lock = d;
				CFG_ADJUST_TIMEOUT: adj_to = d;
				CFG_VOLUME_STEP: step = d[STEP_W-1:0];
				CFG_OFFSET_LIMIT: ofs_lim = d[VOL_W-1:0];
				CFG_MAX_VOLUME: max_vol = d[VOL_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_tick(bit a, bit b, bit sw);
			int delta, d, vmax, lim, second;
			bit s_both, s_second, act, rdr;
			knob_result_t r;
			delta = 0;
			s_both = 0;
			s_second = 0;
			act = 0;
			rdr = 0;
			vmax = vol_ceiling();
			lim = (ofs_lim > VOL_CEIL) ? int'(VOL_CEIL) : int'(ofs_lim);

			enc_wait = tick_up(enc_wait);
			btn_wait = tick_up(btn_wait);
			idle_cnt = tick_up(idle_cnt);

			if (a != prev_a && enc_wait >= enc_lock) begin
				if (!a)
					b_latch = b;
				else if (b_latch && !b) begin
					delta = -1;
					enc_wait = '0;
				end else if (!b_latch && b) begin
					delta = 1;
					enc_wait = '0;
				end
			end
			prev_a = a;

			if (mode == MODE_ADJUST && idle_cnt > adj_to) begin
				mode = MODE_MAIN;
				rdr = 1;
				n_timeouts++;
			end

			if (delta != 0) begin
				d = delta * int'(step);
				rdr = 1;
				n_steps++;
				if (mode == MODE_MENU)
					menu_pos = clip(menu_pos + delta, 0, MENU_COUNT - 1);
				else if (mode == MODE_ADJUST) begin
					offset = clip(offset + d, -lim, lim);
					idle_cnt = '0;
					s_second = 1;
				end else begin
					master = clip(master + d, 0, vmax);
					if (master == 0)
						offset = 0;
					s_both = 1;
				end
			end

			if (!sw && prev_sw && btn_wait > btn_lock) begin
				btn_wait = '0;
				rdr = 1;
				n_presses++;
				if (mode == MODE_MENU) begin
					act = (menu_pos != MENU_COUNT - 1);
					mode = MODE_MAIN;
				end else if (mode == MODE_ADJUST) begin
					mode = MODE_MENU;
					menu_pos = 0;
				end else begin
					mode = MODE_ADJUST;
					idle_cnt = '0;
				end
			end
			prev_sw = sw;
			if (act)
				n_actions++;

			second = clip(master + offset, 0, vmax);
			if (master == 0 && !s_second)
				second = 0;

			r.first_volume = VOL_W'(master);
			r.second_volume = VOL_W'(second);
			r.send_both = s_both;
			r.send_second = s_second;
			r.ui_mode = mode;
			r.menu_index = 2'(menu_pos);
			r.offset_value = OFS_W'(offset);
			r.menu_action = act;
			r.redraw = rdr;
			expected_q.push_back(r);
		endfunction

		function string show(knob_result_t r);
			return $sformatf("vol1=%0d vol2=%0d both=%0b second=%0b mode=%0d %s",
				r.first_volume, r.second_volume, r.send_both, r.send_second, r.ui_mode,
				$sformatf("menu=%0d ofs=%0d act=%0b redraw=%0b", r.menu_index,
					$signed(r.offset_value), r.menu_action, r.redraw));
		endfunction

		function void check_result(knob_result_t got);
			knob_result_t want;
			n_results++;
			if (expected_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("result %0d with nothing pending: %s", n_results, show(got));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				n_bad++;
				if (n_bad <= 10) begin
					$display("result %0d mismatch", n_results);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction

	endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives encoder and switch ticks into the knob controller under a range of
// settings: two short directed runs, then phases of well-formed detents and
// presses mixed with pin noise, with random gaps and stalls on both sides
// and one long output hold. Every result is checked in order.
// ----------------------------------------------------------------------------
module testbench;

	import rkvc_pkg::*;
	import knob_check_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 12;
	localparam int PHASE_TICKS = 132;
	localparam int HOLD_PHASE = 5;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic pin_a = 1'b1;
	logic pin_b = 1'b0;
	logic pin_sw = 1'b1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VOL_W-1:0] first_volume, second_volume;
	logic send_both, send_second, menu_action, redraw;
	logic [1:0] ui_mode, menu_index;
	logic signed [OFS_W-1:0] offset_value;
	logic cfg_wr_en = 1'b0;
	cfg_idx_t cfg_index = CFG_INITIAL_VOLUME;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	knob_scoreboard sb = new();
	logic [CFG_DATA_W-1:0] plan [7];
	bit gaps_on = 1'b0;
	bit long_hold_req = 1'b0;
	bit cur_a = 1'b1, cur_b = 1'b0, cur_sw = 1'b1;
	int ticks_sent = 0;
	int cycle_count = 0;

	rotary_knob_volume_controller #(
		.MENU_ENTRIES(MENU_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_a(pin_a),
		.pin_b(pin_b),
		.pin_sw(pin_sw),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.first_volume(first_volume),
		.second_volume(second_volume),
		.send_both(send_both),
		.send_second(send_second),
		.ui_mode(ui_mode),
		.menu_index(menu_index),
		.offset_value(offset_value),
		.menu_action(menu_action),
		.redraw(redraw),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result side: check, then choose stall for the next cycle
	initial begin
		int stall_left;
		knob_result_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = {first_volume, second_volume, send_both, send_second, ui_mode,
					menu_index, offset_value, menu_action, redraw};
				sb.check_result(got);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 12);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic send_tick(bit a, bit b, bit sw);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pin_a <= a;
		pin_b <= b;
		pin_sw <= sw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_tick(a, b, sw);
		cur_a = a;
		cur_b = b;
		cur_sw = sw;
		ticks_sent++;
	endtask

	// one detent: A falls with B latched, then rises with B inverted
	task automatic turn_once(int dir, int dwell);
		bit b_fall;
		b_fall = (dir < 0);
		if (!cur_a)
			send_tick(1'b1, cur_b, cur_sw);
		send_tick(1'b0, b_fall, cur_sw);
		repeat (dwell) send_tick(1'b0, b_fall, cur_sw);
		send_tick(1'b1, !b_fall, cur_sw);
	endtask

	task automatic press(int low_ticks);
		repeat (low_ticks) send_tick(cur_a, cur_b, 1'b0);
		send_tick(cur_a, cur_b, 1'b1);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_all();
		for (int i = 0; i < 7; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= plan[i];
			@(posedge clk);
			sb.write_setting(cfg_idx_t'(i), plan[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic pick_settings(int k);
		case (k)
			0: begin
				plan[CFG_INITIAL_VOLUME] = 0;
				plan[CFG_ENCODER_LOCKOUT] = 0;
				plan[CFG_BUTTON_LOCKOUT] = 0;
				plan[CFG_ADJUST_TIMEOUT] = 0;
				plan[CFG_VOLUME_STEP] = 1;
				plan[CFG_OFFSET_LIMIT] = 0;
				plan[CFG_MAX_VOLUME] = 1;
			end
			1: begin
				plan[CFG_INITIAL_VOLUME] = 127;
				plan[CFG_ENCODER_LOCKOUT] = 16'hFFFF;
				plan[CFG_BUTTON_LOCKOUT] = 16'hFFFF;
				plan[CFG_ADJUST_TIMEOUT] = 16'hFFFF;
				plan[CFG_VOLUME_STEP] = 15;
				plan[CFG_OFFSET_LIMIT] = 127;
				plan[CFG_MAX_VOLUME] = 127;
			end
			2: begin
				plan[CFG_INITIAL_VOLUME] = 60;
				plan[CFG_ENCODER_LOCKOUT] = 1;
				plan[CFG_BUTTON_LOCKOUT] = 2;
				plan[CFG_ADJUST_TIMEOUT] = 20;
				plan[CFG_VOLUME_STEP] = 0;
				plan[CFG_OFFSET_LIMIT] = 30;
				plan[CFG_MAX_VOLUME] = 0;
			end
			default: begin
				plan[CFG_INITIAL_VOLUME] = CFG_DATA_W'($urandom_range(0, 127));
				plan[CFG_ENCODER_LOCKOUT] = CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
					$urandom_range(8, 40) : $urandom_range(0, 4));
				plan[CFG_BUTTON_LOCKOUT] = CFG_DATA_W'($urandom_range(0, 10));
				plan[CFG_ADJUST_TIMEOUT] = ($urandom_range(0, 5) == 0) ?
					16'hFFFF : CFG_DATA_W'($urandom_range(3, 60));
				plan[CFG_VOLUME_STEP] = CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
					$urandom_range(0, 15) : $urandom_range(1, 10));
				plan[CFG_OFFSET_LIMIT] = CFG_DATA_W'($urandom_range(0, 127));
				plan[CFG_MAX_VOLUME] = CFG_DATA_W'($urandom_range(1, 127));
			end
		endcase
	endtask

	task automatic run_phase(int n_ticks);
		int stop, pick;
		stop = ticks_sent + n_ticks;
		while (ticks_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				turn_once($urandom_range(0, 1) ? 1 : -1, $urandom_range(0, 2));
			else if (pick < 75)
				press($urandom_range(1, 3));
			else if (pick < 87)
				repeat ($urandom_range(1, 30)) send_tick(cur_a, cur_b, cur_sw);
			else
				repeat ($urandom_range(1, 4))
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one step up, one press, edges in lockout, all pin levels
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b1, 1'b0, 1'b0);
		wait_drain();

		// no lockouts: clamp at the top, offset down, menu entry with action
		plan[CFG_INITIAL_VOLUME] = 100;
		plan[CFG_ENCODER_LOCKOUT] = 0;
		plan[CFG_BUTTON_LOCKOUT] = 0;
		plan[CFG_ADJUST_TIMEOUT] = 4;
		plan[CFG_VOLUME_STEP] = 10;
		plan[CFG_OFFSET_LIMIT] = 100;
		plan[CFG_MAX_VOLUME] = 100;
		write_all();
		turn_once(1, 0);
		press(1);
		turn_once(-1, 0);
		press(1);
		turn_once(1, 0);
		press(1);
		wait_drain();

		for (int k = 0; k < PHASES; k++) begin
			pick_settings(k);
			write_all();
			gaps_on = (k < PHASES - 2) && (k % 3 != 2) && (k != HOLD_PHASE);
			if (k == HOLD_PHASE)
				long_hold_req = 1'b1;
			run_phase(PHASE_TICKS);
			wait_drain();
		end

		gaps_on = 1'b0;
		repeat (4) @(posedge clk);
		$display("summary: %0d ticks over %0d setting phases, %0d results checked",
			ticks_sent, PHASES + 2, sb.n_results);
		$display("summary: %0d steps, %0d presses, %0d menu actions, %0d timeouts, %0d bad",
			sb.n_steps, sb.n_presses, sb.n_actions, sb.n_timeouts, sb.n_bad);
		if (sb.n_bad == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rkvc_pkg.sv
hw/rtl/rotary_knob_volume_controller.sv
tb/knob_check_pkg.sv
tb/testbench.sv
